### hw/rtl/prdd_pkg.sv
// Package for the row pivoting / dominance block.
// Holds the controller state enum, mode codes, request/result payloads and
// command/status structs.
package prdd_pkg;

    localparam logic [1:0] MODE_LOAD_MATRIX = 2'd0;
    localparam logic [1:0] MODE_LOAD_RHS    = 2'd1;
    localparam logic [1:0] MODE_RUN         = 2'd2;

    // input request payload
    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value;
    } req_t;

    // result payload
    typedef struct packed {
        logic [5:0]         position;
        logic [5:0]         source_row;
        logic signed [31:0] rhs_value;
        logic               dominant;
        logic               last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIV_RD,
        ST_PIV_CMP,
        ST_PIV_SWAP,
        ST_DOM_RD,
        ST_DOM_ACC,
        ST_DOM_CHK,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_SEND
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_mat;     // write matrix entry from input request
        logic load_rhs;     // write rhs entry from input request
        logic init_col;     // start pivot scan of column i
        logic piv_rd;       // issue read of (k, i)
        logic piv_cmp;      // compare returned magnitude
        logic piv_swap;     // swap row_map[i] and row_map[piv]
        logic dom_init;     // start dominance, set flag
        logic dom_acc;      // accumulate returned magnitude
        logic dom_chk;      // compare diagonal with sum
        logic out_cap;      // capture output payload
        logic inc_i;
        logic inc_k;
        logic clr_k;
    } prdd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic k_last;       // k == n-1
        logic i_last;       // i == n-1
    } prdd_sts_t;

endpackage

### hw/rtl/prdd_if.sv
// Valid/ready channel interface carrying a generic payload type.
// Depends on nothing.
interface prdd_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/pivot_rows_diagonal_dominance.sv
// Top level of the row pivoting and strict diagonal dominance block.
// Depends on prdd_pkg, prdd_if, prdd_ctrl, prdd_dp, prdd_ram.
//
// Load requests (mode 0 matrix entry, mode 1 vector entry) are taken one per
// cycle while the block is idle and write through the row map into the
// matrix and vector RAMs. A run request (mode 2) walks the matrix: pivot
// search reads each column from the diagonal down, n(n+1)/2 entries in all,
// and swaps the row map once per column; the dominance pass reads all n*n
// entries plus one check per row; then n results leave, held by any output
// stall. The matrix RAM has one read port; no request is taken during a run.
module pivot_rows_diagonal_dominance #(
    parameter int MAX_N      = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    prdd_if.sink       in_ch,
    prdd_if.source     out_ch
);
    prdd_pkg::prdd_cmd_t cmd;
    prdd_pkg::prdd_sts_t sts;
    logic [6:0] size_reg;
    logic       ok_mat, ok_rhs, in_ok;

    // matrix_size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 7'd8;
        end
        else if (cfg_we)
        begin
            size_reg <= cfg_wdata;
        end
    end

    // bad indexes and mode 3 are simply consumed
    always_comb
    begin
        unique case (in_ch.data.mode)
            prdd_pkg::MODE_LOAD_MATRIX: in_ok = ok_mat;
            prdd_pkg::MODE_LOAD_RHS:    in_ok = ok_rhs;
            prdd_pkg::MODE_RUN:         in_ok = 1'b1;
            default:                    in_ok = 1'b0;
        endcase
    end

    prdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_mode  (in_ch.data.mode),
        .in_ok    (in_ok),
        .in_ready (in_ch.ready),
        .out_ready(out_ch.ready),
        .out_valid(out_ch.valid),
        .sts      (sts),
        .cmd      (cmd)
    );

    prdd_dp #(.MAX_N(MAX_N), .VALUE_BITS(VALUE_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .size_reg    (size_reg),
        .in_row      (in_ch.data.row),
        .in_col      (in_ch.data.col),
        .in_value    (in_ch.data.value),
        .in_ok_mat   (ok_mat),
        .in_ok_rhs   (ok_rhs),
        .o_position  (out_ch.data.position),
        .o_source_row(out_ch.data.source_row),
        .o_rhs_value (out_ch.data.rhs_value),
        .o_dominant  (out_ch.data.dominant),
        .o_last      (out_ch.data.last)
    );

`ifndef SYNTHESIS
    // output is never valid while the input is ready to take a request
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken while result pending");
    // a result on the final row returns the block to accepting requests
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.data.last) |=> in_ch.ready)
        else $error("block did not return to idle after last result");
`endif
endmodule

### hw/rtl/prdd_ram.sv
// Generic single write / single read RAM with registered read data.
// Depends on nothing.
module prdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hw/rtl/prdd_ctrl.sv
// Controller state machine for pivoting, dominance check and result output.
// Depends on prdd_pkg.
module prdd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_mode,
    input  logic               in_ok,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    input  prdd_pkg::prdd_sts_t sts,
    output prdd_pkg::prdd_cmd_t cmd
);
    prdd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prdd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            prdd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_ok)
                begin
                    if (in_mode == prdd_pkg::MODE_LOAD_MATRIX)
                    begin
                        cmd.load_mat = 1'b1;
                    end
                    else if (in_mode == prdd_pkg::MODE_LOAD_RHS)
                    begin
                        cmd.load_rhs = 1'b1;
                    end
                    else if (in_mode == prdd_pkg::MODE_RUN)
                    begin
                        cmd.init_col = 1'b1;
                        state_next   = prdd_pkg::ST_PIV_RD;
                    end
                end
            end
            prdd_pkg::ST_PIV_RD:
            begin
                cmd.piv_rd = 1'b1;
                state_next = prdd_pkg::ST_PIV_CMP;
            end
            prdd_pkg::ST_PIV_CMP:
            begin
                cmd.piv_cmp = 1'b1;
                if (sts.k_last)
                begin
                    state_next = prdd_pkg::ST_PIV_SWAP;
                end
                else
                begin
                    cmd.inc_k  = 1'b1;
                    state_next = prdd_pkg::ST_PIV_RD;
                end
            end
            prdd_pkg::ST_PIV_SWAP:
            begin
                cmd.piv_swap = 1'b1;
                if (sts.i_last)
                begin
                    cmd.dom_init = 1'b1;
                    state_next   = prdd_pkg::ST_DOM_RD;
                end
                else
                begin
                    cmd.inc_i    = 1'b1;
                    cmd.init_col = 1'b1;
                    state_next   = prdd_pkg::ST_PIV_RD;
                end
            end
            prdd_pkg::ST_DOM_RD:
            begin
                // read address (i, k) is applied by the datapath
                state_next = prdd_pkg::ST_DOM_ACC;
            end
            prdd_pkg::ST_DOM_ACC:
            begin
                cmd.dom_acc = 1'b1;
                if (sts.k_last)
                begin
                    state_next = prdd_pkg::ST_DOM_CHK;
                end
                else
                begin
                    cmd.inc_k  = 1'b1;
                    state_next = prdd_pkg::ST_DOM_RD;
                end
            end
            prdd_pkg::ST_DOM_CHK:
            begin
                cmd.dom_chk = 1'b1;
                cmd.clr_k   = 1'b1;
                if (sts.i_last)
                begin
                    cmd.dom_init = 1'b0;
                    state_next   = prdd_pkg::ST_OUT_RD;
                end
                else
                begin
                    cmd.inc_i  = 1'b1;
                    state_next = prdd_pkg::ST_DOM_RD;
                end
            end
            prdd_pkg::ST_OUT_RD:
            begin
                // rhs read address follows row_map[i]
                state_next = prdd_pkg::ST_OUT_WAIT;
            end
            prdd_pkg::ST_OUT_WAIT:
            begin
                cmd.out_cap = 1'b1;
                state_next  = prdd_pkg::ST_OUT_SEND;
            end
            prdd_pkg::ST_OUT_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (sts.i_last)
                    begin
                        state_next = prdd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.inc_i  = 1'b1;
                        state_next = prdd_pkg::ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = prdd_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

### hw/rtl/prdd_dp.sv
// Datapath: matrix and rhs memories, row map, pivot search and dominance sums.
// Depends on prdd_pkg and prdd_ram.
module prdd_dp #(
    parameter int MAX_N      = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  prdd_pkg::prdd_cmd_t      cmd,
    output prdd_pkg::prdd_sts_t      sts,
    input  logic [6:0]               size_reg,
    input  logic [5:0]               in_row,
    input  logic [5:0]               in_col,
    input  logic signed [31:0]       in_value,
    output logic                     in_ok_mat,
    output logic                     in_ok_rhs,
    output logic [5:0]               o_position,
    output logic [5:0]               o_source_row,
    output logic signed [31:0]       o_rhs_value,
    output logic                     o_dominant,
    output logic                     o_last
);
    localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int AW = $clog2(MAX_N * MAX_N);
    localparam int VB = VALUE_BITS;
    localparam logic [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic [VB:0]   VMAXX = {2'b00, {(VB-1){1'b1}}};

    // effective size, clamped
    logic [IW-1:0] nm1;
    always_comb
    begin
        if (size_reg == 7'd0)
        begin
            nm1 = '0;
        end
        else if (size_reg >= 7'(MAX_N))
        begin
            nm1 = IW'(MAX_N - 1);
        end
        else
        begin
            nm1 = IW'(size_reg - 7'd1);
        end
    end

    assign in_ok_mat = ({1'b0, in_row} < 7'(MAX_N)) && ({1'b0, in_col} < 7'(MAX_N));
    assign in_ok_rhs = ({1'b0, in_row} < 7'(MAX_N));

    // saturate load value into VB bits
    logic [VB-1:0] ld_val;
    always_comb
    begin
        if (VB >= 32)
        begin
            ld_val = VB'($signed(in_value));
        end
        else if ($signed(in_value) > $signed(64'(VMAX)))
        begin
            ld_val = VMAX;
        end
        else if ($signed(in_value) < -$signed(64'(VMAX)) - 64'sd1)
        begin
            ld_val = ~VMAX;
        end
        else
        begin
            ld_val = VB'($signed(in_value));
        end
    end

    logic [IW-1:0] map_reg [MAX_N];
    logic [IW-1:0] i_reg, k_reg, piv_reg;
    logic [VB-1:0] best_reg, sum_reg, diag_reg;
    logic          dom_reg;

    // memories
    logic          mat_we;
    logic [AW-1:0] mat_waddr, mat_raddr;
    logic [VB-1:0] mat_rdata, rhs_rdata;
    logic [IW-1:0] row_sel, col_sel;

    assign mat_we    = cmd.load_mat;
    assign mat_waddr = AW'(map_reg[in_row[IW-1:0]]) * AW'(MAX_N) + AW'(in_col[IW-1:0]);
    assign row_sel   = cmd.piv_rd ? k_reg : i_reg;
    assign col_sel   = cmd.piv_rd ? i_reg : k_reg;
    assign mat_raddr = AW'(map_reg[row_sel]) * AW'(MAX_N) + AW'(col_sel);

    prdd_ram #(.WIDTH(VB), .DEPTH(MAX_N * MAX_N)) u_mat (
        .clk  (clk),
        .we   (mat_we),
        .waddr(mat_waddr),
        .wdata(ld_val),
        .raddr(mat_raddr),
        .rdata(mat_rdata)
    );

    prdd_ram #(.WIDTH(VB), .DEPTH(MAX_N)) u_rhs (
        .clk  (clk),
        .we   (cmd.load_rhs),
        .waddr(map_reg[in_row[IW-1:0]]),
        .wdata(ld_val),
        .raddr(map_reg[i_reg]),
        .rdata(rhs_rdata)
    );

    // saturated magnitude of read data
    logic [VB-1:0] mag;
    always_comb
    begin
        if (mat_rdata[VB-1])
        begin
            mag = (mat_rdata == ~VMAX) ? VMAX : VB'(-mat_rdata);
        end
        else
        begin
            mag = mat_rdata;
        end
    end

    logic [VB:0] sum_add;
    assign sum_add = {1'b0, sum_reg} + {1'b0, mag};

    assign sts.k_last = (k_reg == nm1);
    assign sts.i_last = (i_reg == nm1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MAX_N; r++)
            begin
                map_reg[r] <= IW'(r);
            end
            i_reg   <= '0;
            k_reg   <= '0;
            piv_reg <= '0;
            dom_reg <= 1'b1;
        end
        else
        begin
            if (cmd.init_col)
            begin
                // k starts at i (diagonal), ties favor later rows via >=
                k_reg   <= cmd.inc_i ? i_reg + IW'(1) : (cmd.piv_swap ? i_reg : '0);
                piv_reg <= cmd.inc_i ? i_reg + IW'(1) : '0;
                if (!cmd.inc_i)
                begin
                    i_reg <= '0;
                end
            end
            if (cmd.piv_swap)
            begin
                map_reg[i_reg]   <= map_reg[piv_reg];
                map_reg[piv_reg] <= map_reg[i_reg];
            end
            if (cmd.inc_i)
            begin
                i_reg <= i_reg + IW'(1);
            end
            if (cmd.inc_k)
            begin
                k_reg <= k_reg + IW'(1);
            end
            if (cmd.clr_k || cmd.dom_init)
            begin
                k_reg <= '0;
            end
            if (cmd.dom_init)
            begin
                i_reg   <= '0;
                dom_reg <= 1'b1;
            end
            if (cmd.dom_chk && !(diag_reg > sum_reg))
            begin
                dom_reg <= 1'b0;
            end
            if (cmd.piv_cmp && (k_reg == i_reg || mag >= best_reg))
            begin
                piv_reg <= k_reg;
            end
            if (cmd.dom_chk && cmd.clr_k && sts.i_last)
            begin
                i_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.piv_cmp && (k_reg == i_reg || mag >= best_reg))
        begin
            best_reg <= mag;
        end
        if (cmd.dom_init || cmd.dom_chk)
        begin
            sum_reg <= '0;
        end
        else if (cmd.dom_acc)
        begin
            if (k_reg == i_reg)
            begin
                diag_reg <= mag;
            end
            else
            begin
                sum_reg <= (sum_add > VMAXX) ? VMAX : sum_add[VB-1:0];
            end
        end
        if (cmd.out_cap)
        begin
            o_position   <= 6'(i_reg);
            o_source_row <= 6'(map_reg[i_reg]);
            o_rhs_value  <= 32'($signed(rhs_rdata));
            o_dominant   <= dom_reg;
            o_last       <= (i_reg == nm1);
        end
    end
endmodule

### tb/prdd_tb_pkg.sv
// Testbench-only codes for the pivot/dominance testbench.
// Request and result payloads come from prdd_pkg.
package prdd_tb_pkg;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

endpackage

### tb/testbench.sv
// Testbench for pivot_rows_diagonal_dominance: drives load/run requests with
// random gaps and output stalls, predicts pivot order and dominance flag.
// Depends on prdd_pkg, prdd_if, prdd_tb_pkg and the block's RTL.
`timescale 1ns / 100ps

// Pivot predictor and result checker. Keeps its own copy of the stores,
// the row map and the size register.
class pivot_scoreboard;
    logic signed [31:0] mat [8][8];
    logic signed [31:0] rhs [8];
    logic [2:0]         rmap [8];
    logic [6:0]         size_reg;
    prdd_pkg::res_t     pending [$];
    int                 mismatches;
    int                 results_seen;
    int                 runs;
    int                 dominant_runs;

    function new();
        size_reg = 7'd8;
        for (int i = 0; i < 8; i++)
            rmap[i] = i[2:0];
        mismatches = 0;
        results_seen = 0;
        runs = 0;
        dominant_runs = 0;
    endfunction

    function void set_size(logic [6:0] v);
        size_reg = v;
    endfunction

    // |x| saturated to the largest positive value
    function logic [31:0] abs_sat(logic signed [31:0] x);
        if (x == 32'sh8000_0000)
            return 32'h7fff_ffff;
        return (x < 0) ? -x : x;
    endfunction

    function logic [31:0] entry_abs(int lrow, int c);
        return abs_sat(mat[rmap[lrow]][c]);
    endfunction

    function void note_request(prdd_pkg::req_t r);
        int             n;
        int             piv;
        logic [31:0]    best;
        logic [31:0]    v;
        logic [2:0]     t;
        logic [33:0]    sum;
        logic           dom;
        prdd_pkg::res_t e;
        if (r.mode == prdd_pkg::MODE_LOAD_MATRIX) begin
            if (r.row < 8 && r.col < 8)
                mat[rmap[r.row]][r.col] = r.value;
            return;
        end
        if (r.mode == prdd_pkg::MODE_LOAD_RHS) begin
            if (r.row < 8)
                rhs[rmap[r.row]] = r.value;
            return;
        end
        if (r.mode != prdd_pkg::MODE_RUN)
            return;
        n = size_reg;
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        for (int i = 0; i < n; i++) begin
            piv = i;
            best = entry_abs(i, i);
            for (int k = i + 1; k < n; k++) begin
                v = entry_abs(k, i);
                if (v >= best) begin
                    best = v;
                    piv = k;
                end
            end
            t = rmap[i];
            rmap[i] = rmap[piv];
            rmap[piv] = t;
        end
        dom = 1'b1;
        for (int i = 0; i < n; i++) begin
            sum = '0;
            for (int j = 0; j < n; j++) begin
                if (j != i) begin
                    sum += entry_abs(i, j);
                    if (sum > 34'h7fff_ffff)
                        sum = 34'h7fff_ffff;
                end
            end
            if (!({2'b00, entry_abs(i, i)} > sum))
                dom = 1'b0;
        end
        runs++;
        if (dom) dominant_runs++;
        for (int i = 0; i < n; i++) begin
            e.position   = i[5:0];
            e.source_row = {3'b000, rmap[i]};
            e.rhs_value  = rhs[rmap[i]];
            e.dominant   = dom;
            e.last       = (i == n - 1);
            pending.push_back(e);
        end
    endfunction

    function void check_result(prdd_pkg::res_t a);
        prdd_pkg::res_t e;
        results_seen++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result %p", a);
            return;
        end
        e = pending.pop_front();
        if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result mismatch, expected %p, got %p", e, a);
        end
    endfunction
endclass

module testbench;

    localparam int ITEM_TARGET = 380;
    localparam int STALL_LIMIT = 5000;   // cycles without any handshake
    localparam int SETTLE      = 40;     // cycles to let a run fully drain

    logic clk;
    logic rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    prdd_if #(.payload_t(prdd_pkg::req_t)) in_ch ();
    prdd_if #(.payload_t(prdd_pkg::res_t)) out_ch ();

    pivot_rows_diagonal_dominance i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    pivot_scoreboard sb;
    int  items_sent;
    bit  quiet;          // no idling in the closing stretch
    bit  hold_request;   // asks the receiver for one long stall
    bit  stall_done;     // long stall already exercised
    int  idle_cycles;    // watchdog count

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: no handshake for %0d cycles", STALL_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ---------------- result side ----------------
    // Ready toggles at the falling edge; results are taken at the rising edge.
    initial
    begin : result_sink
        int gap;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                // long hold-off so the block backs up and stalls its input
                out_ch.ready = 1'b0;
                hold_request = 1'b0;
                repeat (300) @(negedge clk);
                out_ch.ready = 1'b1;
            end else if (!quiet && gap == 0 && $urandom_range(4) == 0) begin
                gap = $urandom_range(1, 3);
                out_ch.ready = 1'b0;
            end else if (gap > 0) begin
                gap--;
                out_ch.ready = (gap == 0);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data);
    end

    // ---------------- request side ----------------
    // Called right after a falling edge; returns right after the falling
    // edge that follows acceptance.
    task automatic send_request(input prdd_pkg::req_t r);
        int gap;
        if (!quiet && $urandom_range(5) == 0) begin
            gap = $urandom_range(1, 3);
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(r);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic load_entry(input logic [1:0] m, input int r, input int c,
                              input logic [31:0] v);
        prdd_pkg::req_t q;
        q.mode  = m;
        q.row   = r[5:0];
        q.col   = c[5:0];
        q.value = v;
        send_request(q);
    endtask

    task automatic run_pivot();
        load_entry(prdd_pkg::MODE_RUN, $urandom_range(63), $urandom_range(63), $urandom);
    endtask

    // Size changes only when the block is idle and all results are in.
    task automatic write_size(input logic [6:0] v);
        in_ch.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.set_size(v);
    endtask

    function automatic logic [31:0] pick_value(input int kind);
        case (kind)
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom_range(0, 32'h0003_ffff) ^
                            ($urandom_range(1) ? 32'hffff_ffff : 32'h0);
        endcase
    endfunction

    // Loads an n x n block and its vector. With heavy_diag set, diagonals are
    // large so that the dominance flag comes out true now and then.
    task automatic load_system(input int n, input bit heavy_diag);
        logic [31:0] v;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
                if (heavy_diag)
                    v = (r == c) ? 32'h4000_0000 + $urandom_range(32'h0fff_ffff)
                                 : $urandom_range(32'h000f_ffff);
                else
                    v = pick_value($urandom_range(4, 0) == 0 ? $urandom_range(3) : 4);
                load_entry(prdd_pkg::MODE_LOAD_MATRIX, r, c, v);
            end
            load_entry(prdd_pkg::MODE_LOAD_RHS, r, 0, $urandom);
        end
    endtask

    function automatic logic [6:0] pick_size();
        int s;
        s = $urandom_range(15);
        if (s == 0)  return 7'd0;
        if (s == 1)  return 7'd127;
        if (s == 2)  return 7'd64;
        if (s == 3)  return 7'd8;
        return 7'($urandom_range(1, 4));
    endfunction

    initial
    begin : stimulus
        int             n;
        logic [6:0]     sz;
        prdd_pkg::req_t q;
        sb = new();
        items_sent   = 0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        stall_done   = 1'b0;
        idle_cycles  = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 7'd0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Fill every entry once so no later run reads an unwritten cell.
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++)
                load_entry(prdd_pkg::MODE_LOAD_MATRIX, r, c, $urandom_range(32'h0001_0000));
            load_entry(prdd_pkg::MODE_LOAD_RHS, r, 0, $urandom);
        end

        // --- directed ---
        // Diagonal exactly equal to the off-diagonal sum must fail.
        write_size(7'd2);
        load_entry(prdd_pkg::MODE_LOAD_MATRIX, 0, 0, 32'h0004_0000);
        load_entry(prdd_pkg::MODE_LOAD_MATRIX, 0, 1, 32'hfffc_0000);
        load_entry(prdd_pkg::MODE_LOAD_MATRIX, 1, 0, 32'h0001_0000);
        load_entry(prdd_pkg::MODE_LOAD_MATRIX, 1, 1, 32'h0008_0000);
        load_entry(prdd_pkg::MODE_LOAD_RHS, 0, 0, 32'h7fff_ffff);
        load_entry(prdd_pkg::MODE_LOAD_RHS, 1, 0, 32'h8000_0000);
        run_pivot();
        // Equal magnitudes of opposite sign, and most negative vs most
        // positive: the later row wins the pivot.
        load_entry(prdd_pkg::MODE_LOAD_MATRIX, 0, 0, 32'h8000_0000);
        load_entry(prdd_pkg::MODE_LOAD_MATRIX, 1, 0, 32'h7fff_ffff);
        run_pivot();
        load_entry(prdd_pkg::MODE_LOAD_MATRIX, 0, 0, 32'hfffe_0000);
        load_entry(prdd_pkg::MODE_LOAD_MATRIX, 1, 0, 32'h0002_0000);
        run_pivot();
        // Ignored requests: out-of-range indexes and the unused mode.
        load_entry(prdd_pkg::MODE_LOAD_MATRIX, 63, 0, 32'hdead_beef);
        load_entry(prdd_pkg::MODE_LOAD_MATRIX, 0, 63, 32'hdead_beef);
        load_entry(prdd_pkg::MODE_LOAD_RHS, 8, 0, 32'hdead_beef);
        load_entry(prdd_tb_pkg::MODE_UNUSED, 0, 0, 32'hdead_beef);
        run_pivot();
        // Size extremes: zero clamps to one, large clamps to the array size.
        write_size(7'd0);
        run_pivot();
        write_size(7'd127);
        run_pivot();

        // --- random ---
        while (items_sent < ITEM_TARGET) begin
            if (items_sent > ITEM_TARGET - 60)
                quiet = 1'b1;
            if ($urandom_range(3) != 0) begin
                // well-formed: size, full system load, run
                sz = pick_size();
                write_size(sz);
                n = (sz == 0) ? 1 : (sz > 8 ? 8 : sz);
                load_system(n, $urandom_range(2) == 0);
                run_pivot();
                if ($urandom_range(2) == 0)
                    run_pivot();   // second run on the permuted rows
            end else begin
                // noise: any field value, including out of range and mode 3
                repeat ($urandom_range(3, 8)) begin
                    q.mode  = 2'($urandom_range(3));
                    q.row   = 6'($urandom_range(63));
                    q.col   = 6'($urandom_range(63));
                    q.value = $urandom;
                    send_request(q);
                end
            end
            // One long receiver stall with runs stacked behind it.
            if (!quiet && !stall_done && sb.runs > 8) begin
                stall_done   = 1'b1;
                hold_request = 1'b1;
                run_pivot();
                run_pivot();
                run_pivot();
            end
        end

        in_ch.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Summary: %0d requests, %0d runs (%0d dominant), %0d results checked",
                 items_sent, sb.runs, sb.dominant_runs, sb.results_seen);
        if (sb.mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("Mismatches: %0d", sb.mismatches);
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

### pivot_rows_diagonal_dominance.f
hw/rtl/prdd_pkg.sv
hw/rtl/prdd_if.sv
hw/rtl/prdd_ram.sv
hw/rtl/prdd_ctrl.sv
hw/rtl/prdd_dp.sv
hw/rtl/pivot_rows_diagonal_dominance.sv
tb/prdd_tb_pkg.sv
tb/testbench.sv
